@@ hdl/ppd_pkg.sv @@
// Shared types and constants for the point to polyline distance block.
package ppd_pkg;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_ISSUE,
      S_WAIT,
      S_UPDATE,
      S_EMIT
   } state_type;

   // Arithmetic steps of one segment measurement.
   typedef enum logic [3:0] {
      ST_DXWX,
      ST_DYWY,
      ST_DXDX,
      ST_DYDY,
      ST_DXWY,
      ST_DYWX,
      ST_EXEX,
      ST_EYEY,
      ST_CRCR,
      ST_DIV,
      ST_SQRT
   } step_type;

   // Operations of the shared bit-serial arithmetic unit.
   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } arith_op_type;

   // Request from the sequencer to the arithmetic unit.
   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_req_type;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUERY_X     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUERY_Y     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLOSED_MODE = 2'd2;

endpackage

@@ hdl/point_to_polyline_distance.sv @@
// A vertex that closes a segment keeps the block busy while every product and the root, and for a
// projection inside the segment also the quotient, go bit by bit through one shared unit; the
// inside case takes longer. A closing segment in closed mode adds a second measurement; a first
// vertex that is not the last starts no measurement.
// The block takes one vertex at a time; the next transfer is taken once the sequencer is idle.
// Reset (synchronous, active high) clears the query point, the mode and the running minimum.
// The result register lets a new vertex enter while an earlier result still waits.
module point_to_polyline_distance
   import ppd_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [COORD_WIDTH-1:0]     req_vertex_x,
   input  logic [COORD_WIDTH-1:0]     req_vertex_y,
   input  logic                       req_last_vertex,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [COORD_WIDTH:0]       rsp_min_distance,
   output logic                       rsp_no_segment,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]     csr_data
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int N  = 2*DW + 1;
   localparam logic [DW-1:0] DIST_MAX = {DW{1'b1}};

   // Widened difference of two coordinates.
   function automatic logic [DW-1:0] diff(input logic [COORD_WIDTH-1:0] a,
                                          input logic [COORD_WIDTH-1:0] b);
      return {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
   endfunction

   function automatic logic [N-1:0] ext_n(input logic [DW-1:0] x);
      return {{(N-DW){x[DW-1]}}, x};
   endfunction

   function automatic logic [2*N-1:0] ext_w(input logic [DW-1:0] x);
      return {{(2*N-DW){x[DW-1]}}, x};
   endfunction

   state_type state_ff, state_in;
   step_type  step_ff, step_in;

   logic [COORD_WIDTH-1:0] query_x_ff, query_x_in;
   logic [COORD_WIDTH-1:0] query_y_ff, query_y_in;
   logic                   closed_ff, closed_in;
   logic [COORD_WIDTH-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic [COORD_WIDTH-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [COORD_WIDTH-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_WIDTH-1:0] seg_ax_ff, seg_ax_in, seg_ay_ff, seg_ay_in;
   logic [COORD_WIDTH-1:0] seg_bx_ff, seg_bx_in, seg_by_ff, seg_by_in;
   logic                   last_ff, last_in;
   logic                   closing_ff, closing_in;
   logic                   have_prev_ff, have_prev_in;
   logic                   had_seg_ff, had_seg_in;
   logic [DW-1:0]          best_ff, best_in;
   logic [DW-1:0]          dist_ff, dist_in;
   logic [DW-1:0]          dx_ff, dx_in, dy_ff, dy_in, wx_ff, wx_in, wy_ff, wy_in;
   logic [DW-1:0]          ex_ff, ex_in, ey_ff, ey_in;
   logic [N-1:0]           t0_ff, t0_in, dot_ff, dot_in, len2_ff, len2_in, cr_ff, cr_in;
   logic [2*N-1:0]         sq_ff, sq_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]          rsp_dist_ff, rsp_dist_in;
   logic                   rsp_noseg_ff, rsp_noseg_in;

   arith_req_type          arith_req;
   logic [2*N-1:0]         arith_a;
   logic [N-1:0]           arith_b;
   logic                   arith_done;
   logic [2*N-1:0]         arith_result;
   logic [N-1:0]           prod_low;
   logic                   dot_nonpos;

   ppd_arith #(
      .N(N)
   ) u_arith (
      .clock  (clock),
      .reset  (reset),
      .req    (arith_req),
      .opa    (arith_a),
      .opb    (arith_b),
      .done   (arith_done),
      .result (arith_result)
   );

   assign prod_low   = arith_result[N-1:0];
   assign dot_nonpos = dot_ff[N-1] || (dot_ff == '0);
   assign csr_ready  = 1'b1;

   // Next state, datapath updates and unit requests.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      query_x_in   = query_x_ff;
      query_y_in   = query_y_ff;
      closed_in    = closed_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      seg_ax_in    = seg_ax_ff;
      seg_ay_in    = seg_ay_ff;
      seg_bx_in    = seg_bx_ff;
      seg_by_in    = seg_by_ff;
      last_in      = last_ff;
      closing_in   = closing_ff;
      have_prev_in = have_prev_ff;
      had_seg_in   = had_seg_ff;
      best_in      = best_ff;
      dist_in      = dist_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      t0_in        = t0_ff;
      dot_in       = dot_ff;
      len2_in      = len2_ff;
      cr_in        = cr_ff;
      sq_in        = sq_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_noseg_in = rsp_noseg_ff;

      req_stall       = (state_ff != S_IDLE);
      arith_req.start = 1'b0;
      arith_req.op    = OP_MUL;
      arith_a         = '0;
      arith_b         = '0;

      // Configuration writes.
      if (csr_valid) begin
         unique case (csr_index)
            CSR_QUERY_X:     query_x_in = csr_data;
            CSR_QUERY_Y:     query_y_in = csr_data;
            CSR_CLOSED_MODE: closed_in  = csr_data[0];
            default: ;
         endcase
      end

      // The waiting result leaves on a completed transfer.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cur_x_in     = req_vertex_x;
               cur_y_in     = req_vertex_y;
               last_in      = req_last_vertex;
               prev_x_in    = req_vertex_x;
               prev_y_in    = req_vertex_y;
               have_prev_in = 1'b1;
               closing_in   = req_last_vertex & closed_ff;
               if (have_prev_ff) begin
                  seg_ax_in  = prev_x_ff;
                  seg_ay_in  = prev_y_ff;
                  seg_bx_in  = req_vertex_x;
                  seg_by_in  = req_vertex_y;
                  had_seg_in = 1'b1;
                  state_in   = S_SETUP;
               end else begin
                  first_x_in = req_vertex_x;
                  first_y_in = req_vertex_y;
                  if (req_last_vertex && closed_ff) begin
                     // A lone vertex closes onto itself.
                     seg_ax_in  = req_vertex_x;
                     seg_ay_in  = req_vertex_y;
                     seg_bx_in  = req_vertex_x;
                     seg_by_in  = req_vertex_y;
                     closing_in = 1'b0;
                     had_seg_in = 1'b1;
                     state_in   = S_SETUP;
                  end else if (req_last_vertex) begin
                     state_in = S_EMIT;
                  end
               end
            end
         end

         S_SETUP: begin
            dx_in    = diff(seg_bx_ff, seg_ax_ff);
            dy_in    = diff(seg_by_ff, seg_ay_ff);
            wx_in    = diff(query_x_ff, seg_ax_ff);
            wy_in    = diff(query_y_ff, seg_ay_ff);
            step_in  = ST_DXWX;
            state_in = S_ISSUE;
         end

         S_ISSUE: begin
            arith_req.start = 1'b1;
            unique case (step_ff)
               ST_DXWX: begin arith_a = ext_w(dx_ff); arith_b = ext_n(wx_ff); end
               ST_DYWY: begin arith_a = ext_w(dy_ff); arith_b = ext_n(wy_ff); end
               ST_DXDX: begin arith_a = ext_w(dx_ff); arith_b = ext_n(dx_ff); end
               ST_DYDY: begin arith_a = ext_w(dy_ff); arith_b = ext_n(dy_ff); end
               ST_DXWY: begin arith_a = ext_w(dx_ff); arith_b = ext_n(wy_ff); end
               ST_DYWX: begin arith_a = ext_w(dy_ff); arith_b = ext_n(wx_ff); end
               ST_EXEX: begin arith_a = ext_w(ex_ff); arith_b = ext_n(ex_ff); end
               ST_EYEY: begin arith_a = ext_w(ey_ff); arith_b = ext_n(ey_ff); end
               ST_CRCR: begin
                  arith_a = {{N{cr_ff[N-1]}}, cr_ff};
                  arith_b = cr_ff;
               end
               ST_DIV: begin
                  arith_req.op = OP_DIV;
                  arith_a      = sq_ff;
                  arith_b      = len2_ff;
               end
               ST_SQRT: begin
                  arith_req.op = OP_SQRT;
                  arith_a      = sq_ff;
               end
               default: ;
            endcase
            state_in = S_WAIT;
         end

         S_WAIT: begin
            if (arith_done) begin
               state_in = S_ISSUE;
               unique case (step_ff)
                  ST_DXWX: begin t0_in = prod_low; step_in = ST_DYWY; end
                  ST_DYWY: begin dot_in = t0_ff + prod_low; step_in = ST_DXDX; end
                  ST_DXDX: begin t0_in = prod_low; step_in = ST_DYDY; end
                  ST_DYDY: begin len2_in = t0_ff + prod_low; step_in = ST_DXWY; end
                  ST_DXWY: begin t0_in = prod_low; step_in = ST_DYWX; end
                  ST_DYWX: begin
                     cr_in = t0_ff - prod_low;
                     // Projection before the start, past the end, or inside.
                     if (dot_nonpos) begin
                        ex_in   = wx_ff;
                        ey_in   = wy_ff;
                        step_in = ST_EXEX;
                     end else if ($signed(dot_ff) >= $signed(len2_ff)) begin
                        ex_in   = diff(query_x_ff, seg_bx_ff);
                        ey_in   = diff(query_y_ff, seg_by_ff);
                        step_in = ST_EXEX;
                     end else begin
                        step_in = ST_CRCR;
                     end
                  end
                  ST_EXEX: begin t0_in = prod_low; step_in = ST_EYEY; end
                  ST_EYEY: begin
                     sq_in   = {{N{1'b0}}, t0_ff + prod_low};
                     step_in = ST_SQRT;
                  end
                  ST_CRCR: begin sq_in = arith_result; step_in = ST_DIV; end
                  ST_DIV:  begin sq_in = arith_result; step_in = ST_SQRT; end
                  ST_SQRT: begin
                     dist_in  = (|arith_result[N-1:DW]) ? DIST_MAX : arith_result[DW-1:0];
                     state_in = S_UPDATE;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_UPDATE: begin
            if (dist_ff < best_ff) begin
               best_in = dist_ff;
            end
            priority if (closing_ff) begin
               seg_ax_in  = cur_x_ff;
               seg_ay_in  = cur_y_ff;
               seg_bx_in  = first_x_ff;
               seg_by_in  = first_y_ff;
               closing_in = 1'b0;
               state_in   = S_SETUP;
            end else if (last_ff) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = had_seg_ff ? best_ff : DIST_MAX;
               rsp_noseg_in = !had_seg_ff;
               first_x_in   = '0;
               first_y_in   = '0;
               prev_x_in    = '0;
               prev_y_in    = '0;
               best_in      = DIST_MAX;
               have_prev_in = 1'b0;
               had_seg_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_min_distance = rsp_dist_ff;
   assign rsp_no_segment   = rsp_noseg_ff;

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         query_x_ff   <= '0;
         query_y_ff   <= '0;
         closed_ff    <= 1'b0;
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         best_ff      <= DIST_MAX;
         have_prev_ff <= 1'b0;
         had_seg_ff   <= 1'b0;
         closing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         query_x_ff   <= query_x_in;
         query_y_ff   <= query_y_in;
         closed_ff    <= closed_in;
         first_x_ff   <= first_x_in;
         first_y_ff   <= first_y_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         best_ff      <= best_in;
         have_prev_ff <= have_prev_in;
         had_seg_ff   <= had_seg_in;
         closing_ff   <= closing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      seg_ax_ff    <= seg_ax_in;
      seg_ay_ff    <= seg_ay_in;
      seg_bx_ff    <= seg_bx_in;
      seg_by_ff    <= seg_by_in;
      last_ff      <= last_in;
      dist_ff      <= dist_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      wx_ff        <= wx_in;
      wy_ff        <= wy_in;
      ex_ff        <= ex_in;
      ey_ff        <= ey_in;
      t0_ff        <= t0_in;
      dot_ff       <= dot_in;
      len2_ff      <= len2_in;
      cr_ff        <= cr_in;
      sq_ff        <= sq_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_noseg_ff <= rsp_noseg_in;
   end

`ifndef SYNTH
   // The arithmetic unit finishes only while the sequencer waits for it.
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      arith_done |-> (state_ff == S_WAIT))
      else $error("arithmetic result arrived outside the wait state");

   // A measured segment implies a stored previous vertex.
   a_seg_has_prev: assert property (@(posedge clock) disable iff (reset)
      had_seg_ff |-> have_prev_ff)
      else $error("segment recorded without a previous vertex");

   // Emitting presents a result and clears the polyline state.
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !(rsp_valid_ff && rsp_stall)) |=>
         (rsp_valid && !have_prev_ff && (state_ff == S_IDLE)))
      else $error("emit did not present a result and clear state");
`endif

endmodule

@@ hdl/ppd_arith.sv @@
// Bit-serial signed multiplier, restoring divider and integer square root sharing one datapath.
module ppd_arith
   import ppd_pkg::*;
#(
   parameter int N = 67
) (
   input  logic          clock,
   input  logic          reset,
   input  arith_req_type req,
   input  logic [2*N-1:0] opa,
   input  logic [N-1:0]   opb,
   output logic          done,
   output logic [2*N-1:0] result
);

   localparam int CNT_W = $clog2(2*N+1);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   arith_op_type   op_ff, op_in;
   logic           neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [2*N-1:0] work_ff, work_in;
   logic [N-1:0]   divisor_ff, divisor_in;
   logic [N:0]     rem_ff, rem_in;
   logic [N-1:0]   root_ff, root_in;

   logic [N-1:0]   mag_a;
   logic [N-1:0]   mag_b;
   logic [N:0]     mul_sum;
   logic [N:0]     div_shift;
   logic           div_ge;
   logic [N+2:0]   sq_shift;
   logic [N+2:0]   sq_trial;
   logic [N+2:0]   sq_diff;
   logic           sq_ge;

   // One multiplier bit, one quotient bit or one root bit per cycle.
   always_comb begin
      mag_a     = opa[N-1] ? (~opa[N-1:0] + N'(1)) : opa[N-1:0];
      mag_b     = opb[N-1] ? (~opb + N'(1)) : opb;
      mul_sum   = {1'b0, work_ff[2*N-1:N]} + (work_ff[0] ? {1'b0, divisor_ff} : '0);
      div_shift = {rem_ff[N-1:0], work_ff[2*N-1]};
      div_ge    = (div_shift >= {1'b0, divisor_ff});
      sq_shift  = {rem_ff, work_ff[2*N-1:2*N-2]};
      sq_trial  = {1'b0, root_ff, 2'b01};
      sq_diff   = sq_shift - sq_trial;
      sq_ge     = (sq_shift >= sq_trial);

      busy_in    = busy_ff;
      done_in    = 1'b0;
      op_in      = op_ff;
      neg_in     = neg_ff;
      cnt_in     = cnt_ff;
      work_in    = work_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;

      if (busy_ff) begin
         unique case (op_ff)
            OP_MUL: begin
               work_in = {mul_sum, work_ff[N-1:1]};
            end
            OP_DIV: begin
               rem_in  = div_ge ? (div_shift - {1'b0, divisor_ff}) : div_shift;
               work_in = {work_ff[2*N-2:0], div_ge};
            end
            OP_SQRT: begin
               rem_in  = sq_ge ? sq_diff[N:0] : sq_shift[N:0];
               root_in = {root_ff[N-2:0], sq_ge};
               work_in = {work_ff[2*N-3:0], 2'b00};
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         rem_in  = '0;
         root_in = '0;
         neg_in  = 1'b0;
         unique case (req.op)
            OP_MUL: begin
               work_in    = {{N{1'b0}}, mag_a};
               divisor_in = mag_b;
               neg_in     = opa[N-1] ^ opb[N-1];
               cnt_in     = CNT_W'(N);
            end
            OP_DIV: begin
               work_in    = opa;
               divisor_in = opb;
               cnt_in     = CNT_W'(2*N);
            end
            OP_SQRT: begin
               work_in = opa;
               cnt_in  = CNT_W'(N);
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   // Result view of the working registers.
   always_comb begin
      unique case (op_ff)
         OP_MUL:  result = neg_ff ? (~work_ff + (2*N)'(1)) : work_ff;
         OP_DIV:  result = work_ff;
         OP_SQRT: result = {{N{1'b0}}, root_ff};
         default: result = work_ff;
      endcase
   end

   assign done = done_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      neg_ff     <= neg_in;
      cnt_ff     <= cnt_in;
      work_ff    <= work_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
   end

endmodule
